[src/pfa_pkg.sv]
`timescale 1ns / 1ps
package pfa_pkg;
    localparam int FRAME_COUNT   = 64;
    localparam int PAGE_SIZE     = 32;
    localparam int MAX_PROCESSES = 8;
    localparam int MAX_PAGES     = 64;

    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FCNT_W  = $clog2(FRAME_COUNT + 1);
    localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int NPG_W   = 17;
    localparam int PT_DEPTH = MAX_PROCESSES * MAX_PAGES;
    localparam int PT_AW   = SLOT_W + PAGE_W;

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_RESIZE    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_FINISH    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOMEM   = 3'd1,
        ST_NOPROC  = 3'd2,
        ST_BADPAGE = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_DECIDE, S_GROW_SCAN, S_GROW_WRITE,
        S_SHRINK_RD, S_SHRINK_WAIT, S_SHRINK_FREE, S_XLATE_RD, S_XLATE_WAIT, S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pid;
        logic [15:0] size_bytes;
        logic [5:0]  page_number;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] frame;
        logic [6:0] page_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic lookup;      // capture slot search results
        logic scan_reset;  // restart frame scan at zero
        logic scan_step;   // advance frame scan
        logic grow_write;  // claim scanned frame, append page
        logic shrink_rd;   // read last page's frame entry
        logic shrink_free; // release frame, drop last page
        logic xlate_rd;    // read translated page entry
        logic create_slot; // claim free slot for create
        logic release_slot;// release slot on finish
        logic set_result;  // build the result item
        logic [2:0] status;
    } pfa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] operation;
        logic found;
        logic has_free_slot;
        logic nomem_create;
        logic nomem_grow;
        logic need_grow;
        logic need_shrink;
        logic grow_more;   // another page still missing after this append
        logic shrink_more; // another page still to drop after this release
        logic bad_page;
        logic scan_free;
    } pfa_stat_t;
endpackage

[src/paged_frame_allocator_unit.sv]
`timescale 1ns / 1ps
// Each item passes lookup and decide; each page grown scans past used frames
// and then writes, and each page freed is read, waited on and released.
// One item at a time: a new item is taken only after the last result is loaded.
// Reset: rst_n asynchronous, active low; clears bitmap, free count, slot
// valid bits and control. Slot pids and page table are undefined until written.
module paged_frame_allocator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pfa_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pfa_pkg::out_item_t  out_data
);
    pfa_pkg::pfa_cmd_t  cmd;
    pfa_pkg::pfa_stat_t stat;
    logic               res_load;
    logic               out_valid_reg;

    // Hold the result in the output register until taken; the controller
    // waits in its done state while that register is still occupied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_valid_reg && out_stall),
        .res_load (res_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfa_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .res     (out_data)
    );
endmodule

[src/pfa_ctrl.sv]
`timescale 1ns / 1ps
module pfa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_busy,
    output logic             res_load,
    input  pfa_pkg::pfa_stat_t stat,
    output pfa_pkg::pfa_cmd_t  cmd
);
    pfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::S_IDLE:
                if (in_valid) state_next = pfa_pkg::S_LOOKUP;
            pfa_pkg::S_LOOKUP:
                state_next = pfa_pkg::S_DECIDE;
            pfa_pkg::S_DECIDE:
            begin
                state_next = pfa_pkg::S_DONE;
                case (stat.operation)
                    pfa_pkg::OP_CREATE:
                        if (stat.has_free_slot && !stat.nomem_create && stat.need_grow)
                            state_next = pfa_pkg::S_GROW_SCAN;
                    pfa_pkg::OP_RESIZE:
                        if (stat.found)
                        begin
                            if (stat.need_shrink)
                                state_next = pfa_pkg::S_SHRINK_RD;
                            else if (stat.need_grow && !stat.nomem_grow)
                                state_next = pfa_pkg::S_GROW_SCAN;
                        end
                    pfa_pkg::OP_TRANSLATE:
                        if (stat.found && !stat.bad_page)
                            state_next = pfa_pkg::S_XLATE_RD;
                    pfa_pkg::OP_FINISH:
                        if (stat.found && stat.need_shrink)
                            state_next = pfa_pkg::S_SHRINK_RD;
                    default: state_next = pfa_pkg::S_DONE;
                endcase
            end
            pfa_pkg::S_GROW_SCAN:
                if (stat.scan_free) state_next = pfa_pkg::S_GROW_WRITE;
            pfa_pkg::S_GROW_WRITE:
                state_next = stat.grow_more ? pfa_pkg::S_GROW_SCAN : pfa_pkg::S_DONE;
            pfa_pkg::S_SHRINK_RD:   state_next = pfa_pkg::S_SHRINK_WAIT;
            pfa_pkg::S_SHRINK_WAIT: state_next = pfa_pkg::S_SHRINK_FREE;
            pfa_pkg::S_SHRINK_FREE:
                state_next = stat.shrink_more ? pfa_pkg::S_SHRINK_RD : pfa_pkg::S_DONE;
            pfa_pkg::S_XLATE_RD:    state_next = pfa_pkg::S_XLATE_WAIT;
            pfa_pkg::S_XLATE_WAIT:  state_next = pfa_pkg::S_DONE;
            pfa_pkg::S_DONE:
                if (!out_busy) state_next = pfa_pkg::S_IDLE;
            default: state_next = pfa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.status = pfa_pkg::ST_OK;
        in_stall = 1'b1;
        res_load = 1'b0;
        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            pfa_pkg::S_LOOKUP: cmd.lookup = 1'b1;
            pfa_pkg::S_DECIDE:
            begin
                cmd.scan_reset = 1'b1;
                if (stat.operation == pfa_pkg::OP_CREATE && stat.has_free_slot
                    && !stat.nomem_create)
                    cmd.create_slot = 1'b1;
            end
            pfa_pkg::S_GROW_SCAN:
                if (!stat.scan_free) cmd.scan_step = 1'b1;
            pfa_pkg::S_GROW_WRITE:  cmd.grow_write = 1'b1;
            pfa_pkg::S_SHRINK_RD:   cmd.shrink_rd = 1'b1;
            pfa_pkg::S_SHRINK_FREE: cmd.shrink_free = 1'b1;
            pfa_pkg::S_XLATE_RD:    cmd.xlate_rd = 1'b1;
            pfa_pkg::S_DONE:
            begin
                if (!out_busy)
                begin
                    res_load = 1'b1;
                    cmd.set_result = 1'b1;
                    if (stat.operation == pfa_pkg::OP_FINISH && stat.found)
                        cmd.release_slot = 1'b1;
                end
                case (stat.operation)
                    pfa_pkg::OP_CREATE:
                        cmd.status = !stat.has_free_slot ? pfa_pkg::ST_FULL :
                                     stat.nomem_create ? pfa_pkg::ST_NOMEM : pfa_pkg::ST_OK;
                    pfa_pkg::OP_RESIZE:
                        cmd.status = !stat.found ? pfa_pkg::ST_NOPROC :
                                     stat.nomem_grow ? pfa_pkg::ST_NOMEM : pfa_pkg::ST_OK;
                    pfa_pkg::OP_TRANSLATE:
                        cmd.status = !stat.found ? pfa_pkg::ST_NOPROC :
                                     stat.bad_page ? pfa_pkg::ST_BADPAGE : pfa_pkg::ST_OK;
                    default:
                        cmd.status = !stat.found ? pfa_pkg::ST_NOPROC : pfa_pkg::ST_OK;
                endcase
            end
            default: ;
        endcase
    end
endmodule

[src/pfa_datapath.sv]
`timescale 1ns / 1ps
module pfa_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pfa_pkg::in_item_t   in_item,
    input  pfa_pkg::pfa_cmd_t   cmd,
    output pfa_pkg::pfa_stat_t  stat,
    output pfa_pkg::out_item_t  res
);
    localparam int FW = pfa_pkg::FRAME_W;
    localparam int SW = pfa_pkg::SLOT_W;
    localparam int PW = pfa_pkg::PAGE_W;
    localparam int CW = pfa_pkg::PCNT_W;
    localparam int NW = pfa_pkg::NPG_W;

    logic [pfa_pkg::FRAME_COUNT-1:0]   used_reg;
    logic [pfa_pkg::FCNT_W-1:0]        free_reg;
    logic [pfa_pkg::MAX_PROCESSES-1:0] valid_reg;
    logic [31:0]                       spid_reg  [pfa_pkg::MAX_PROCESSES];
    logic [CW-1:0]                     spages_reg[pfa_pkg::MAX_PROCESSES];
    logic [FW-1:0]                     pt_mem    [pfa_pkg::PT_DEPTH];
    logic [FW-1:0]                     pt_rd_reg;

    pfa_pkg::in_item_t item_reg;
    logic [SW-1:0] slot_reg;
    logic          found_reg, has_free_reg;
    logic [NW-1:0] want_reg;
    logic [CW-1:0] cur_reg;
    logic [FW-1:0] scan_reg;

    logic [SW-1:0] hit_idx, free_idx;
    logic          hit, any_free;
    logic [NW-1:0] want_c, cur_w, free_w, lim_w;

    // priority search over the slot table, lowest slot wins
    always_comb
    begin
        hit = 1'b0; hit_idx = '0; any_free = 1'b0; free_idx = '0;
        for (int s = pfa_pkg::MAX_PROCESSES - 1; s >= 0; s--)
        begin
            if (valid_reg[s] && spid_reg[s] == item_reg.pid)
            begin
                hit = 1'b1; hit_idx = SW'(s);
            end
            if (!valid_reg[s])
            begin
                any_free = 1'b1; free_idx = SW'(s);
            end
        end
    end

    assign want_c = NW'((17'(item_reg.size_bytes) + 17'(pfa_pkg::PAGE_SIZE - 1))
                        / pfa_pkg::PAGE_SIZE);
    assign cur_w  = NW'(cur_reg);
    assign free_w = NW'(free_reg);
    assign lim_w  = NW'(pfa_pkg::MAX_PAGES);

    // free + held pages stays constant while growing, so the verdict holds
    // through to the result
    assign stat.operation     = item_reg.operation;
    assign stat.found         = found_reg;
    assign stat.has_free_slot = has_free_reg;
    assign stat.nomem_create  = (want_reg > lim_w) || (want_reg > free_w + cur_w);
    assign stat.nomem_grow    = (want_reg > lim_w) || (want_reg > free_w + cur_w);
    assign stat.need_grow     = want_reg > cur_w;
    assign stat.need_shrink   = (item_reg.operation == pfa_pkg::OP_FINISH) ?
                                (cur_reg != '0) : (want_reg < cur_w);
    assign stat.grow_more     = want_reg > cur_w + NW'(1);
    assign stat.shrink_more   = (item_reg.operation == pfa_pkg::OP_FINISH) ?
                                (cur_reg > CW'(1)) : (want_reg + NW'(1) < cur_w);
    assign stat.bad_page      = NW'(item_reg.page_number) >= cur_w;
    assign stat.scan_free     = !used_reg[scan_reg];

    logic [pfa_pkg::PT_AW-1:0] wr_addr, rd_addr;
    assign wr_addr = {slot_reg, cur_reg[PW-1:0]};
    assign rd_addr = cmd.xlate_rd ? {slot_reg, item_reg.page_number[PW-1:0]}
                                  : {slot_reg, PW'(cur_reg - 1'b1)};

    always_ff @(posedge clk)
    begin
        if (cmd.grow_write)
            pt_mem[wr_addr] <= scan_reg;
        if (cmd.shrink_rd || cmd.xlate_rd)
            pt_rd_reg <= pt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.lookup)
        begin
            found_reg     <= hit;
            has_free_reg  <= any_free;
            want_reg      <= want_c;
            slot_reg      <= (item_reg.operation == pfa_pkg::OP_CREATE) ? free_idx : hit_idx;
            cur_reg       <= (item_reg.operation == pfa_pkg::OP_CREATE) ? '0 : spages_reg[hit_idx];
        end
        if (cmd.scan_reset)
            scan_reg <= '0;
        else if (cmd.scan_step)
            scan_reg <= scan_reg + 1'b1;
        if (cmd.grow_write)
        begin
            cur_reg <= cur_reg + 1'b1;
            spages_reg[slot_reg] <= cur_reg + 1'b1;
        end
        if (cmd.shrink_free)
        begin
            cur_reg <= cur_reg - 1'b1;
            spages_reg[slot_reg] <= cur_reg - 1'b1;
        end
        if (cmd.create_slot)
        begin
            spid_reg[slot_reg]   <= item_reg.pid;
            spages_reg[slot_reg] <= '0;
        end
        if (cmd.set_result)
        begin
            res.status <= cmd.status;
            res.frame  <= (cmd.status == pfa_pkg::ST_OK &&
                           item_reg.operation == pfa_pkg::OP_TRANSLATE) ?
                          6'(pt_rd_reg) : 6'd0;
            res.page_count <= (cmd.status == pfa_pkg::ST_FULL ||
                               cmd.status == pfa_pkg::ST_NOPROC ||
                               item_reg.operation == pfa_pkg::OP_FINISH ||
                               (item_reg.operation == pfa_pkg::OP_CREATE &&
                                cmd.status == pfa_pkg::ST_NOMEM)) ? 7'd0 : 7'(cur_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            free_reg  <= pfa_pkg::FCNT_W'(pfa_pkg::FRAME_COUNT);
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.grow_write)
            begin
                used_reg[scan_reg] <= 1'b1;
                free_reg <= free_reg - 1'b1;
            end
            if (cmd.shrink_free && used_reg[pt_rd_reg])
            begin
                used_reg[pt_rd_reg] <= 1'b0;
                free_reg <= free_reg + 1'b1;
            end
            if (cmd.create_slot)
                valid_reg[slot_reg] <= 1'b1;
            if (cmd.release_slot)
                valid_reg[slot_reg] <= 1'b0;
        end
    end
endmodule

[src/pfa_checker.sv]
`timescale 1ns / 1ps
module pfa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input pfa_pkg::out_item_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= pfa_pkg::ST_FULL)
        else $error("status code out of range");
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while one in flight");
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != pfa_pkg::ST_OK |-> out_data.frame == 6'd0)
        else $error("frame nonzero on error");
endmodule

bind paged_frame_allocator_unit pfa_checker u_pfa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[sim/paged_frame_allocator_unit_checker.sv]
`timescale 1ns / 1ps
module paged_frame_allocator_unit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  pfa_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  pfa_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending
);
    bit                 used_q [pfa_pkg::FRAME_COUNT];
    int                 free_q;
    bit                 live_q [pfa_pkg::MAX_PROCESSES];
    logic [31:0]        owner_q [pfa_pkg::MAX_PROCESSES];
    int                 npages_q [pfa_pkg::MAX_PROCESSES];
    int                 ptab_q [pfa_pkg::MAX_PROCESSES][pfa_pkg::MAX_PAGES];
    pfa_pkg::out_item_t expected_q [$];

    assign pending = expected_q.size();

    function automatic int pages_needed(logic [15:0] bytes);
        return (int'(bytes) + pfa_pkg::PAGE_SIZE - 1) / pfa_pkg::PAGE_SIZE;
    endfunction

    function automatic int slot_of(logic [31:0] pid);
        for (int s = 0; s < pfa_pkg::MAX_PROCESSES; s++)
            if (live_q[s] && owner_q[s] == pid)
                return s;
        return -1;
    endfunction

    // lowest free frames, page order
    function automatic void grow_to(int s, int n);
        while (npages_q[s] < n)
        begin
            for (int f = 0; f < pfa_pkg::FRAME_COUNT; f++)
                if (!used_q[f])
                begin
                    used_q[f] = 1'b1;
                    free_q--;
                    ptab_q[s][npages_q[s]] = f;
                    break;
                end
            npages_q[s]++;
        end
    endfunction

    function automatic void shrink_to(int s, int n);
        while (npages_q[s] > n)
        begin
            npages_q[s]--;
            used_q[ptab_q[s][npages_q[s]]] = 1'b0;
            free_q++;
        end
    endfunction

    function automatic pfa_pkg::out_item_t allocate(pfa_pkg::in_item_t it);
        pfa_pkg::out_item_t r;
        int s;
        int n;
        r = '0;
        r.status = pfa_pkg::ST_OK;
        if (pfa_pkg::op_t'(it.operation) == pfa_pkg::OP_CREATE)
        begin
            n = pages_needed(it.size_bytes);
            s = -1;
            for (int k = pfa_pkg::MAX_PROCESSES - 1; k >= 0; k--)
                if (!live_q[k])
                    s = k;
            if (s < 0)
                r.status = pfa_pkg::ST_FULL;
            else if (n > pfa_pkg::MAX_PAGES || n > free_q)
                r.status = pfa_pkg::ST_NOMEM;
            else
            begin
                live_q[s] = 1'b1;
                owner_q[s] = it.pid;
                npages_q[s] = 0;
                grow_to(s, n);
                r.page_count = 7'(n);
            end
        end
        else
        begin
            s = slot_of(it.pid);
            if (s < 0)
                r.status = pfa_pkg::ST_NOPROC;
            else if (pfa_pkg::op_t'(it.operation) == pfa_pkg::OP_RESIZE)
            begin
                n = pages_needed(it.size_bytes);
                if (n <= npages_q[s])
                    shrink_to(s, n);
                else if (n > pfa_pkg::MAX_PAGES || n - npages_q[s] > free_q)
                    r.status = pfa_pkg::ST_NOMEM;
                else
                    grow_to(s, n);
                r.page_count = 7'(npages_q[s]);
            end
            else if (pfa_pkg::op_t'(it.operation) == pfa_pkg::OP_TRANSLATE)
            begin
                r.page_count = 7'(npages_q[s]);
                if (int'(it.page_number) >= npages_q[s])
                    r.status = pfa_pkg::ST_BADPAGE;
                else
                    r.frame = 6'(ptab_q[s][it.page_number]);
            end
            else
            begin
                shrink_to(s, 0);
                live_q[s] = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pfa_pkg::out_item_t want;
        if (!rst_n)
        begin
            free_q = pfa_pkg::FRAME_COUNT;
            for (int f = 0; f < pfa_pkg::FRAME_COUNT; f++)
                used_q[f] = 1'b0;
            for (int s = 0; s < pfa_pkg::MAX_PROCESSES; s++)
            begin
                live_q[s] = 1'b0;
                npages_q[s] = 0;
            end
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(allocate(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected item: status %0d frame %0d page_count %0d",
                        out_data.status, out_data.frame, out_data.page_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status,
                            out_data.status);
                        fail_count++;
                    end
                    if (out_data.frame !== want.frame)
                    begin
                        $error("frame: expected %0d, actual %0d", want.frame,
                            out_data.frame);
                        fail_count++;
                    end
                    if (out_data.page_count !== want.page_count)
                    begin
                        $error("page_count: expected %0d, actual %0d", want.page_count,
                            out_data.page_count);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[sim/paged_frame_allocator_unit_tb.sv]
`timescale 1ns / 1ps
module paged_frame_allocator_unit_tb;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pfa_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pfa_pkg::out_item_t out_data;
    int                 fail_count;
    int                 pending;
    bit                 hold_sink = 1'b0;   // long receiver hold-off requested
    bit                 sink_free = 1'b0;   // no random stalls on the output
    logic [31:0]        pid_pool [6];

    always #1 clk = ~clk;

    paged_frame_allocator_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    paged_frame_allocator_unit_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Pick a gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_sink = 1'b0;
            end
            else if (!sink_free && $urandom_range(0, 3) == 0)
            begin
                n = gap_len();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_item(pfa_pkg::op_t op, logic [31:0] pid, logic [15:0] size,
            logic [5:0] page);
        in_data <= '{operation: op, pid: pid, size_bytes: size, page_number: page};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid after an item, idle a random gap, unless the next goes back to back.
    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Step past the last accept edge so its expected item is queued, then wait.
    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Random item biased toward live pids and sizes that fit in the frame pool.
    task automatic send_random();
        int r;
        logic [31:0] pid;
        logic [15:0] size;
        r = $urandom_range(0, 99);
        pid = ($urandom_range(0, 19) == 0) ? $urandom() : pid_pool[$urandom_range(0, 5)];
        if (r < 8)
            size = $urandom();
        else if (r < 12)
            size = 16'hFFFF;
        else
            size = $urandom_range(0, 640);
        r = $urandom_range(0, 99);
        if (r < 30)
            send_item(pfa_pkg::OP_CREATE, pid, size, 6'($urandom()));
        else if (r < 50)
            send_item(pfa_pkg::OP_RESIZE, pid, size, 6'($urandom()));
        else if (r < 82)
            send_item(pfa_pkg::OP_TRANSLATE, pid, size, 6'($urandom_range(0, 63)));
        else
            send_item(pfa_pkg::OP_FINISH, pid, size, 6'($urandom()));
    endtask

    initial
    begin
        pid_pool = '{32'h0, 32'hFFFF_FFFF, 32'h5, 32'hA5A5_5A5A, 32'h8000_0000, 32'h1234};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the boundaries, every operation and the error codes.
        send_item(pfa_pkg::OP_TRANSLATE, 32'h7, 16'h0, 6'd0);      // unknown pid
        send_item(pfa_pkg::OP_RESIZE, 32'h7, 16'd10, 6'd0);
        send_item(pfa_pkg::OP_FINISH, 32'h7, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_CREATE, 32'h0, 16'd0, 6'd0);          // zero-page process
        send_item(pfa_pkg::OP_TRANSLATE, 32'h0, 16'd0, 6'd0);       // bad page
        send_item(pfa_pkg::OP_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 6'd63); // too large
        send_item(pfa_pkg::OP_CREATE, 32'hFFFF_FFFF, 16'd33, 6'd0);  // rounds up to 2
        send_item(pfa_pkg::OP_CREATE, 32'hFFFF_FFFF, 16'd1, 6'd0);   // duplicate pid
        send_item(pfa_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 16'd0, 6'd1);
        send_item(pfa_pkg::OP_RESIZE, 32'h0, 16'd2048, 6'd0);        // out of memory
        send_item(pfa_pkg::OP_RESIZE, 32'hFFFF_FFFF, 16'd1, 6'd0);   // shrink
        send_item(pfa_pkg::OP_RESIZE, 32'h0, 16'd1984, 6'd0);        // take every frame left
        send_item(pfa_pkg::OP_TRANSLATE, 32'h0, 16'd0, 6'd60);
        send_item(pfa_pkg::OP_CREATE, 32'h3, 16'd1, 6'd0);           // no memory left
        send_item(pfa_pkg::OP_CREATE, 32'h4, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_CREATE, 32'h5, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_CREATE, 32'h6, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_CREATE, 32'h8, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_CREATE, 32'h9, 16'd0, 6'd0);           // table now full
        send_item(pfa_pkg::OP_CREATE, 32'hA, 16'd0, 6'd0);           // table full
        send_item(pfa_pkg::OP_FINISH, 32'hFFFF_FFFF, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_FINISH, 32'h0, 16'd0, 6'd0);
        send_item(pfa_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 16'd0, 6'd0);
        in_valid <= 1'b0;

        // Sender pauses until all results are in.
        drain();

        // Random part; partway, stall the receiver for a long stretch.
        for (int i = 0; i < 550; i++)
        begin
            if (i == 200)
                hold_sink = 1'b1;
            if (i == 350)
                sink_free = 1'b1;
            if (i == 450)
                sink_free = 1'b0;
            send_random();
            if (i < 350 || i >= 450)
                idle_gap();
        end
        in_valid <= 1'b0;
        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[paged_frame_allocator_unit.f]
src/pfa_pkg.sv
src/pfa_ctrl.sv
src/pfa_datapath.sv
src/paged_frame_allocator_unit.sv
src/pfa_checker.sv
sim/paged_frame_allocator_unit_checker.sv
sim/paged_frame_allocator_unit_tb.sv
